// ===== design/rme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants of the register machine executor
// Opcodes, the decoded item that crosses the queue, float bit constants and
// the register index reduction.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int REG_COUNT   = 16;
  localparam int REG_IDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int FIELD_IDX_W = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0]  SHIFT_MASK  = 5'd31;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [30:0] EXP_INF_MAG = 31'h7F80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [4:0] {
    OP_IADD  = 5'd0,
    OP_ISUB  = 5'd1,
    OP_IMUL  = 5'd2,
    OP_FADD  = 5'd3,
    OP_FSUB  = 5'd4,
    OP_FMUL  = 5'd5,
    OP_BAND  = 5'd6,
    OP_BOR   = 5'd7,
    OP_BXOR  = 5'd8,
    OP_LSHL  = 5'd9,
    OP_LSHR  = 5'd10,
    OP_ASHL  = 5'd11,
    OP_ASHR  = 5'd12,
    OP_ILT   = 5'd13,
    OP_IEQ   = 5'd14,
    OP_ULT   = 5'd15,
    OP_UEQ   = 5'd16,
    OP_FLT   = 5'd17,
    OP_FEQ   = 5'd18,
    OP_BNOT  = 5'd19,
    OP_LNOT  = 5'd20,
    OP_INEG  = 5'd21,
    OP_FNEG  = 5'd22,
    OP_ITF   = 5'd23,
    OP_FTI   = 5'd24,
    OP_LOADI = 5'd25,
    OP_LOADF = 5'd26,
    OP_MOV   = 5'd27
  } op_e;

  // Decoded item held in the queue between front and back
  typedef struct packed {
    logic        is_start;
    logic        is_float;
    op_e         op;
    reg_idx_t    dest;
    reg_idx_t    src_a;
    reg_idx_t    src_b;
    logic [31:0] value;   // literal, or program input for a start item
    logic        last;
  } item_t;

  typedef struct packed {
    logic        start;
    op_e         op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

  // Register field taken modulo REG_COUNT by repeated subtraction
  function automatic reg_idx_t reg_index(input logic [FIELD_IDX_W-1:0] f);
    logic [6:0] v;
    v = 7'(f);
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(REG_COUNT)) v = v - 7'(REG_COUNT);
    end
    return v[REG_IDX_W-1:0];
  endfunction

endpackage

// ===== design/rme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_ram: generic RAM, one write port, two registered read ports
// Read data shows the contents before a write at the same edge.
// ----------------------------------------------------------------------------
module rme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/rme_fpu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_fpu: single-precision add, subtract and multiply
// Stage A unpacks, handles special operands, aligns and adds or multiplies;
// stage B normalizes by leading zero count; stage C rounds to nearest even.
// ----------------------------------------------------------------------------
module rme_fpu (
  input  logic              clk,
  input  logic              rst,
  input  rme_pkg::fpu_req_t req,
  input  logic              take,
  output rme_pkg::fpu_rsp_t rsp
);
  import rme_pkg::*;

  logic v1, v2;
  logic go;

  // stage A registers
  logic               s1_sp, s1_mul, s1_sub, s1_sign;
  logic [31:0]        s1_spv;
  logic signed [10:0] s1_e;
  logic [26:0]        s1_m;
  logic [47:0]        s1_prod;

  // stage B registers
  logic               s2_sp, s2_sign;
  logic [31:0]        s2_spv;
  logic signed [10:0] s2_e;
  logic [26:0]        s2_m;

  // ---------------- stage A ----------------
  logic [31:0] a, bb, x, y;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, is_mul, swap;
  logic [7:0]  ex_e, ey_e, d, ea_e, eb_e;
  logic [23:0] mx, my, ma, mb;
  logic [26:0] mxs, my27, mys, diff;
  logic [27:0] sum;
  logic [47:0] prod;
  logic        a_sp, a_sub, a_sign;
  logic [31:0] a_spv;
  logic signed [10:0] a_e;
  logic [26:0] a_m;

  assign go = req.start & ~v1 & ~v2;

  always_comb begin
    a      = req.a;
    bb     = (req.op == OP_FSUB) ? (req.b ^ SIGN_BIT) : req.b;
    is_mul = (req.op == OP_FMUL);
    nan_a  = a[30:0] > EXP_INF_MAG;
    nan_b  = bb[30:0] > EXP_INF_MAG;
    inf_a  = a[30:0] == EXP_INF_MAG;
    inf_b  = bb[30:0] == EXP_INF_MAG;
    zero_a = a[30:0] == 31'd0;
    zero_b = bb[30:0] == 31'd0;

    // alignment for the add path
    swap = a[30:0] < bb[30:0];
    x    = swap ? bb : a;
    y    = swap ? a : bb;
    ex_e = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey_e = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx   = {|x[30:23], x[22:0]};
    my   = {|y[30:23], y[22:0]};
    d    = ex_e - ey_e;
    mxs  = {mx, 3'b000};
    my27 = {my, 3'b000};
    mys  = (my27 >> d) | 27'(|(my27 & ~({27{1'b1}} << d)));
    sum  = {1'b0, mxs} + {1'b0, mys};
    diff = mxs - mys;

    // multiply path
    ea_e = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb_e = (bb[30:23] == 8'd0) ? 8'd1 : bb[30:23];
    ma   = {|a[30:23], a[22:0]};
    mb   = {|bb[30:23], bb[22:0]};
    prod = ma * mb;

    a_sp   = 1'b1;
    a_spv  = '0;
    a_sub  = 1'b0;
    a_sign = x[31];
    a_e    = $signed({3'b000, ex_e});
    a_m    = sum[26:0];

    if (nan_a) begin
      a_spv = a | QUIET_BIT;
    end else if (nan_b) begin
      a_spv = req.b | QUIET_BIT;
    end else if (is_mul) begin
      a_sign = a[31] ^ bb[31];
      a_e    = $signed({3'b000, ea_e}) + $signed({3'b000, eb_e}) - 11'sd126;
      if (inf_a || inf_b) begin
        a_spv = (zero_a || zero_b) ? DEFAULT_NAN : {a_sign, EXP_INF_MAG};
      end else if (zero_a || zero_b) begin
        a_spv = {a_sign, 31'd0};
      end else begin
        a_sp = 1'b0;
      end
    end else if (inf_a) begin
      a_spv = (inf_b && (a[31] != bb[31])) ? DEFAULT_NAN : a;
    end else if (inf_b) begin
      a_spv = bb;
    end else if (zero_a && zero_b) begin
      a_spv = {a[31] & bb[31], 31'd0};
    end else if (zero_a) begin
      a_spv = bb;
    end else if (zero_b) begin
      a_spv = a;
    end else if (x[31] == y[31]) begin
      a_sp = 1'b0;
      if (sum[27]) begin
        a_m = sum[27:1] | 27'(sum[0]);
        a_e = $signed({3'b000, ex_e}) + 11'sd1;
      end
    end else if (diff == 27'd0) begin
      a_spv = '0;
    end else begin
      a_sp  = 1'b0;
      a_sub = 1'b1;
      a_m   = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_sp   <= a_sp;
      s1_spv  <= a_spv;
      s1_mul  <= is_mul;
      s1_sub  <= a_sub;
      s1_sign <= a_sign;
      s1_e    <= a_e;
      s1_m    <= a_m;
      s1_prod <= prod;
    end
  end

  // ---------------- stage B ----------------
  logic [5:0]         z;
  logic [4:0]         lz, k;
  logic [47:0]        q;
  logic signed [10:0] em1, b_e;
  logic [26:0]        b_m;

  always_comb begin
    z = '0;
    for (int i = 0; i < 48; i++) begin
      if (s1_prod[i]) z = 6'(47 - i);
    end
    lz = '0;
    for (int i = 0; i < 27; i++) begin
      if (s1_m[i]) lz = 5'(26 - i);
    end
    q   = s1_prod << z;
    em1 = s1_e - 11'sd1;
    k   = ($signed({6'b0, lz}) < em1) ? lz : em1[4:0];
    b_e = s1_e;
    b_m = s1_m;
    if (s1_mul) begin
      b_m = q[47:21] | 27'(|q[20:0]);
      b_e = s1_e - $signed({5'b0, z});
    end else if (s1_sub) begin
      b_m = s1_m << k;
      b_e = s1_e - $signed({6'b0, k});
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      s2_sp   <= s1_sp;
      s2_spv  <= s1_spv;
      s2_sign <= s1_sign;
      s2_e    <= b_e;
      s2_m    <= b_m;
    end
  end

  // ---------------- stage C: underflow shift and rounding ----------------
  logic [10:0]        dd;
  logic [26:0]        cm;
  logic signed [10:0] ce;
  logic [2:0]         rem;
  logic               inc;
  logic [24:0]        mr;

  always_comb begin
    dd = 11'(11'sd1 - s2_e);
    cm = s2_m;
    ce = s2_e;
    if (s2_e < 11'sd1) begin
      cm = (s2_m >> dd) | 27'(|(s2_m & ~({27{1'b1}} << dd)));
      ce = 11'sd1;
    end
    rem = cm[2:0];
    inc = (rem > 3'd4) || ((rem == 3'd4) && cm[3]);
    mr  = {1'b0, cm[26:3]} + 25'(inc);
    if (mr[24]) begin
      mr = mr >> 1;
      ce = ce + 11'sd1;
    end
    rsp.done = v2;
    if (s2_sp) begin
      rsp.result = s2_spv;
    end else if (ce >= 11'sd255) begin
      rsp.result = {s2_sign, EXP_INF_MAG};
    end else begin
      rsp.result = {s2_sign, (mr[23] ? ce[7:0] : 8'd0), mr[22:0]};
    end
  end

  // stage valid flags; the last stage holds until the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1 | (v2 & ~take);
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst) $onehot0({v1, v2}))
    else $error("fpu holds two operations at once");

endmodule

// ===== design/rme_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_front: input acceptance, decode and item queue
// Reduces register fields, classifies start, float and integer items and
// buffers them in a short queue ahead of the back end.
// ----------------------------------------------------------------------------
module rme_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           kind,
  input  logic [4:0]     opcode,
  input  logic [3:0]     dest_reg,
  input  logic [3:0]     src_a_reg,
  input  logic [3:0]     src_b_reg,
  input  logic [31:0]    literal_bits,
  input  logic [31:0]    input_bits,
  input  logic           last,
  output rme_pkg::item_t head,
  output logic           head_valid,
  input  logic           pop
);
  import rme_pkg::*;

  item_t             dec;
  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  // decode
  always_comb begin
    dec.is_start = ~kind;
    dec.op       = op_e'(opcode);
    dec.is_float = kind && ((opcode == OP_FADD) || (opcode == OP_FSUB) ||
                            (opcode == OP_FMUL));
    dec.dest     = reg_index(dest_reg);
    dec.src_a    = reg_index(src_a_reg);
    dec.src_b    = reg_index(src_b_reg);
    dec.value    = kind ? literal_bits : input_bits;
    dec.last     = last;
  end

  assign in_ready   = count < QCNT_W'(QUEUE_DEPTH);
  assign push       = in_valid & in_ready;
  assign head_valid = count != '0;
  assign head       = q[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wptr] <= dec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== design/rme_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_back: execute stage of the register machine
// Reads operands from the register RAM with bypass of the last write, runs
// integer and compare ops directly, float ops in the fpu, and holds the
// result register.
// ----------------------------------------------------------------------------
module rme_back (
  input  logic           clk,
  input  logic           rst,
  input  rme_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    result_bits
);
  import rme_pkg::*;

  item_t              x;
  logic               x_valid, x_adv, x_done, out_free;
  fpu_req_t           freq;
  fpu_rsp_t           frsp;
  logic [31:0]        q_a, q_b, opa, opb, alu, wdata, r0;
  logic               op_writes, wen;
  reg_idx_t           waddr, raddr_a, raddr_b;
  logic               lw_vld;
  reg_idx_t           lw_addr;
  logic [31:0]        lw_data;
  logic [REG_COUNT-1:0] reg_vld;
  logic               nan_a, nan_b, zeros;
  logic [31:0]        key_a, key_b;
  logic [4:0]         n;

  // stage advance
  assign out_free = ~out_valid | out_ready;
  assign x_done   = x_valid && (!x.is_float || frsp.done) && (!x.last || out_free);
  assign x_adv    = ~x_valid | x_done;
  assign pop      = x_adv & head_valid;

  always_ff @(posedge clk) begin
    if (rst) x_valid <= 1'b0;
    else if (x_adv) x_valid <= head_valid;
  end

  always_ff @(posedge clk) begin
    if (pop) x <= head;
  end

  // register RAM, read for the item that sits in the stage next cycle
  assign raddr_a = x_adv ? head.src_a : x.src_a;
  assign raddr_b = x_adv ? head.src_b : x.src_b;

  rme_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
    .clk     (clk),
    .we      (wen),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

  // operand bypass; an entry not written since start reads zero
  assign opa = (lw_vld && lw_addr == x.src_a) ? lw_data :
               (reg_vld[x.src_a] ? q_a : '0);
  assign opb = (lw_vld && lw_addr == x.src_b) ? lw_data :
               (reg_vld[x.src_b] ? q_b : '0);

  // float unit
  assign freq.start = x_valid & x.is_float;
  assign freq.op    = x.op;
  assign freq.a     = opa;
  assign freq.b     = opb;

  rme_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (freq),
    .take (x_done),
    .rsp  (frsp)
  );

  // float compare helpers
  assign nan_a = opa[30:0] > EXP_INF_MAG;
  assign nan_b = opb[30:0] > EXP_INF_MAG;
  assign zeros = (opa[30:0] == 31'd0) && (opb[30:0] == 31'd0);
  assign key_a = opa[31] ? ~opa : (opa | SIGN_BIT);
  assign key_b = opb[31] ? ~opb : (opb | SIGN_BIT);
  assign n     = opb[4:0] & SHIFT_MASK;

  // operation decode
  always_comb begin
    op_writes = 1'b1;
    alu       = '0;
    unique case (x.op)
      OP_IADD:  alu = opa + opb;
      OP_ISUB:  alu = opa - opb;
      OP_IMUL:  alu = opa * opb;
      OP_FADD, OP_FSUB, OP_FMUL: alu = frsp.result;
      OP_BAND:  alu = opa & opb;
      OP_BOR:   alu = opa | opb;
      OP_BXOR:  alu = opa ^ opb;
      OP_LSHL, OP_ASHL: alu = opa << n;
      OP_LSHR:  alu = opa >> n;
      OP_ASHR:  alu = 32'($signed(opa) >>> n);
      OP_ILT:   alu = 32'($signed(opa) < $signed(opb));
      OP_IEQ, OP_UEQ: alu = 32'(opa == opb);
      OP_ULT:   alu = 32'(opa < opb);
      OP_FLT:   alu = 32'(!nan_a && !nan_b && !zeros && (key_a < key_b));
      OP_FEQ:   alu = 32'(!nan_a && !nan_b && (zeros || opa == opb));
      OP_BNOT:  alu = ~opa;
      OP_LNOT:  alu = 32'(opa == 32'd0);
      OP_INEG:  alu = 32'd0 - opa;
      OP_FNEG:  alu = opa ^ SIGN_BIT;
      OP_ITF, OP_FTI, OP_MOV: alu = opa;
      OP_LOADI, OP_LOADF: alu = x.value;
      default:  op_writes = 1'b0;
    endcase
  end

  assign wen   = x_done & (x.is_start | op_writes);
  assign waddr = x.is_start ? '0 : x.dest;
  assign wdata = x.is_start ? x.value : alu;

  // last-write bypass, written-since-start flags and register 0 shadow
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_vld  <= 1'b0;
      reg_vld <= '0;
      r0      <= '0;
    end else begin
      lw_vld <= wen;
      if (x_done && x.is_start) reg_vld <= REG_COUNT'(1);
      else if (wen) reg_vld[waddr] <= 1'b1;
      if (wen && waddr == '0) r0 <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr <= waddr;
    lw_data <= wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (x_done && x.last) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (x_done && x.last) result_bits <= (wen && waddr == '0) ? wdata : r0;
  end

  a_fpu_owner: assert property (@(posedge clk) disable iff (rst)
    frsp.done |-> x_valid && x.is_float)
    else $error("fpu result without a float item in execute");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    x_done && x.is_start |=> reg_vld == REG_COUNT'(1))
    else $error("start did not reset register flags");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    x_done && x.last |-> !out_valid || out_ready)
    else $error("result register overwritten while held");

endmodule

// ===== design/register_machine_executor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_executor_top: register machine instruction executor
// Runs a straight-line program over a 32-bit register file, one item each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per transfer: a start
//   item (kind 0) clears all registers and loads input_bits into register 0;
//   an instruction item (kind 1) applies opcode to the registers. An item
//   with last set produces one transfer on the output channel carrying
//   register 0 (result_bits) after that item.
//   Throughput: one item per cycle unless execute is held: a float op holds it
//   until the three-stage float unit is done, a last item until output is free.
//   A two-entry queue sits between decode and execute, so in_ready depends
//   only on the queue fill, not on the output side.
//   Reset clears the queue, the output valid flag and all registers to zero.
//   When the receiver stalls, the result holds in the output register; the
//   next last-marked item waits in execute and the queue then fills.
// ----------------------------------------------------------------------------
module register_machine_executor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [4:0]  opcode,
  input  logic [3:0]  dest_reg,
  input  logic [3:0]  src_a_reg,
  input  logic [3:0]  src_b_reg,
  input  logic [31:0] literal_bits,
  input  logic [31:0] input_bits,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_bits
);
  import rme_pkg::*;

  item_t head;
  logic  head_valid, pop;

  rme_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .opcode       (opcode),
    .dest_reg     (dest_reg),
    .src_a_reg    (src_a_reg),
    .src_b_reg    (src_b_reg),
    .literal_bits (literal_bits),
    .input_bits   (input_bits),
    .last         (last),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  rme_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_bits (result_bits)
  );

endmodule
